// ----- hw/rtl/tps_pkg.sv -----
package tps_pkg;

    localparam int COORD_W   = 32;
    localparam int VAL_W     = 48;
    localparam int ACC_W     = 51;
    localparam int ADDR_W    = 6;
    localparam int IDX_W     = 4;
    localparam int MUL_STEPS = 4;
    localparam int DIV_STEPS = 10;

    localparam logic signed [VAL_W-1:0] ONE_Q24 = 48'sh000001000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_SEG1,
        S_P_RD,
        S_P_LD,
        S_P_MUL,
        S_P_RND,
        S_P_DIV,
        S_P_FIN,
        S_T_WR,
        S_DONE,
        S_EM_RD,
        S_EM_LD
    } t_state;

    typedef enum logic [1:0] {
        SW_ONE,
        SW_ZERO,
        SW_ACC
    } t_sig_wsel;

    typedef enum logic [1:0] {
        GW_ONE,
        GW_INC,
        GW_PROD
    } t_seg_wsel;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_RND,
        OP_DIV,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic              take;
        logic              new_path;
        logic              sig_we;
        logic [ADDR_W-1:0] sig_waddr;
        t_sig_wsel         sig_wsel;
        logic [ADDR_W-1:0] sig_raddr;
        logic              seg_we;
        logic [ADDR_W-1:0] seg_waddr;
        t_seg_wsel         seg_wsel;
        logic [ADDR_W-1:0] seg_raddr;
        logic [1:0]        inc_sel;
        logic              tens;
        logic [1:0]        m;
        t_op               op;
        logic [1:0]        step;
        logic              acc_clr;
        logic              out_load;
        logic [IDX_W-1:0]  out_index;
        logic              out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/tps_pt_if.sv -----
interface tps_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [tps_pkg::COORD_W-1:0] coord_0;
    logic signed [tps_pkg::COORD_W-1:0] coord_1;
    logic                                first_point;
    logic                                last_point;

    modport source (
        output valid, coord_0, coord_1, first_point, last_point,
        input  ready
    );
    modport sink (
        input  valid, coord_0, coord_1, first_point, last_point,
        output ready
    );
endinterface

// ----- hw/rtl/tps_term_if.sv -----
interface tps_term_if;
    logic                              valid;
    logic                              ready;
    logic [tps_pkg::IDX_W-1:0]         term_index;
    logic signed [tps_pkg::VAL_W-1:0]  term_value;
    logic                              last_term;
    logic                              saturated;

    modport source (
        output valid, term_index, term_value, last_term, saturated,
        input  ready
    );
    modport sink (
        input  valid, term_index, term_value, last_term, saturated,
        output ready
    );
endinterface

// ----- hw/rtl/tps_ctrl.sv -----
module tps_ctrl #(
    parameter int DIMS        = 2,
    parameter int TRUNC_LEVEL = 3,
    parameter int TOTAL       = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_first_point,
    input  logic               i_last_point,
    output logic               o_in_ready,
    input  tps_pkg::t_dp_stat  i_stat,
    output tps_pkg::t_dp_cmd   o_cmd
);

    localparam int KW        = $clog2(TOTAL + 1);
    localparam int SEG1_LAST = (TRUNC_LEVEL >= 1) ? DIMS : 0;

    function automatic int lbase(input int l);
        int off;
        int p;
        off = 0;
        p   = 1;
        for (int i = 0; i < 4; i++) begin
            if (i < l) begin
                off = off + p;
                p   = p * DIMS;
            end
        end
        return off;
    endfunction

    function automatic int dval(input logic [2:0][1:0] d, input int lo, input int n);
        int v;
        v = 0;
        for (int k = 2; k >= 0; k--) begin
            if (k >= lo && k < lo + n) begin
                v = v * DIMS + int'(d[k]);
            end
        end
        return v;
    endfunction

    tps_pkg::t_state  r_state, n_state;
    logic             r_path_open, n_path_open;
    logic             r_last, n_last;
    logic             r_tens, n_tens;
    logic [1:0]       r_lvl, n_lvl;
    logic [1:0]       r_jj, n_jj;
    logic [2:0][1:0]  r_dg, n_dg;
    logic [KW-1:0]    r_k, n_k;
    logic [3:0]       r_stp, n_stp;

    logic [2:0][1:0]  dg_inc;
    logic             lvl_end;
    logic [1:0]       m_cur;
    logic             k_last;

    assign m_cur  = r_tens ? 2'd1 : r_lvl;
    assign k_last = (r_k == KW'(TOTAL - 1));

    always_comb begin
        logic carry;
        carry   = 1'b1;
        lvl_end = 1'b1;
        dg_inc  = r_dg;
        for (int k = 0; k < 3; k++) begin
            if (k < int'(r_lvl)) begin
                if (r_dg[k] != 2'(DIMS - 1)) begin
                    lvl_end = 1'b0;
                end
                if (carry) begin
                    if (r_dg[k] == 2'(DIMS - 1)) begin
                        dg_inc[k] = 2'd0;
                    end else begin
                        dg_inc[k] = r_dg[k] + 2'd1;
                        carry     = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tps_pkg::S_IDLE;
            r_path_open <= 1'b0;
            r_last      <= 1'b0;
            r_tens      <= 1'b0;
            r_lvl       <= '0;
            r_jj        <= '0;
            r_dg        <= '0;
            r_k         <= '0;
            r_stp       <= '0;
        end else begin
            r_state     <= n_state;
            r_path_open <= n_path_open;
            r_last      <= n_last;
            r_tens      <= n_tens;
            r_lvl       <= n_lvl;
            r_jj        <= n_jj;
            r_dg        <= n_dg;
            r_k         <= n_k;
            r_stp       <= n_stp;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_path_open = r_path_open;
        n_last      = r_last;
        n_tens      = r_tens;
        n_lvl       = r_lvl;
        n_jj        = r_jj;
        n_dg        = r_dg;
        n_k         = r_k;
        n_stp       = r_stp;
        case (r_state)
            tps_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_last      = i_last_point;
                    n_path_open = 1'b1;
                    n_k         = '0;
                    if (i_first_point || !r_path_open) begin
                        n_state = tps_pkg::S_CLR;
                    end else begin
                        n_state = tps_pkg::S_SEG1;
                    end
                end
            end
            tps_pkg::S_CLR: begin
                if (k_last) begin
                    n_state = tps_pkg::S_DONE;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            tps_pkg::S_SEG1: begin
                if (r_k == KW'(SEG1_LAST)) begin
                    n_k  = '0;
                    n_dg = '0;
                    n_jj = '0;
                    if (TRUNC_LEVEL >= 2) begin
                        n_tens = 1'b0;
                        n_lvl  = 2'd2;
                    end else begin
                        n_tens = 1'b1;
                        n_lvl  = 2'(TRUNC_LEVEL);
                    end
                    n_state = tps_pkg::S_P_RD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            tps_pkg::S_P_RD: begin
                n_state = tps_pkg::S_P_LD;
            end
            tps_pkg::S_P_LD: begin
                n_stp   = '0;
                n_state = tps_pkg::S_P_MUL;
            end
            tps_pkg::S_P_MUL: begin
                if (r_stp == 4'(tps_pkg::MUL_STEPS - 1)) begin
                    n_state = tps_pkg::S_P_RND;
                end else begin
                    n_stp = r_stp + 4'd1;
                end
            end
            tps_pkg::S_P_RND: begin
                n_stp = '0;
                if (m_cur == 2'd3) begin
                    n_state = tps_pkg::S_P_DIV;
                end else begin
                    n_state = tps_pkg::S_P_FIN;
                end
            end
            tps_pkg::S_P_DIV: begin
                if (r_stp == 4'(tps_pkg::DIV_STEPS - 1)) begin
                    n_state = tps_pkg::S_P_FIN;
                end else begin
                    n_stp = r_stp + 4'd1;
                end
            end
            tps_pkg::S_P_FIN: begin
                n_state = tps_pkg::S_P_RD;
                if (!r_tens) begin
                    n_dg = dg_inc;
                    if (lvl_end) begin
                        n_dg = '0;
                        n_jj = '0;
                        if (r_lvl == 2'(TRUNC_LEVEL)) begin
                            n_tens = 1'b1;
                        end else begin
                            n_lvl = r_lvl + 2'd1;
                        end
                    end
                end else if (r_jj == r_lvl) begin
                    n_state = tps_pkg::S_T_WR;
                end else begin
                    n_jj = r_jj + 2'd1;
                end
            end
            tps_pkg::S_T_WR: begin
                n_jj    = '0;
                n_dg    = dg_inc;
                n_state = tps_pkg::S_P_RD;
                if (lvl_end) begin
                    n_dg = '0;
                    if (r_lvl == 2'd0) begin
                        n_state = tps_pkg::S_DONE;
                    end else begin
                        n_lvl = r_lvl - 2'd1;
                    end
                end
            end
            tps_pkg::S_DONE: begin
                n_k = '0;
                if (r_last) begin
                    n_state = tps_pkg::S_EM_RD;
                end else begin
                    n_state = tps_pkg::S_IDLE;
                end
            end
            tps_pkg::S_EM_RD: begin
                n_state = tps_pkg::S_EM_LD;
            end
            tps_pkg::S_EM_LD: begin
                if (i_stat.out_free) begin
                    if (k_last) begin
                        n_path_open = 1'b0;
                        n_state     = tps_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = tps_pkg::S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = tps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        int lj;
        int lm;
        lj = int'(r_jj);
        lm = int'(r_lvl);
        o_cmd      = '0;
        o_in_ready = 1'b0;

        o_cmd.tens    = r_tens;
        o_cmd.m       = m_cur;
        o_cmd.step    = r_stp[1:0];
        o_cmd.acc_clr = (r_jj == 2'd0);
        o_cmd.inc_sel = r_dg[0];
        o_cmd.sig_wsel = tps_pkg::SW_ACC;
        o_cmd.seg_wsel = tps_pkg::GW_PROD;
        o_cmd.sig_waddr = tps_pkg::ADDR_W'(lbase(lm) + dval(r_dg, 0, lm));
        o_cmd.seg_waddr = tps_pkg::ADDR_W'(lbase(lm) + dval(r_dg, 0, lm));
        o_cmd.sig_raddr = tps_pkg::ADDR_W'(lbase(lj) + dval(r_dg, lm - lj, lj));
        if (r_tens) begin
            o_cmd.seg_raddr = tps_pkg::ADDR_W'(lbase(lm - lj) + dval(r_dg, 0, lm - lj));
        end else begin
            o_cmd.seg_raddr = tps_pkg::ADDR_W'(lbase(lm - 1) + dval(r_dg, 1, lm - 1));
        end
        o_cmd.out_index = tps_pkg::IDX_W'(r_k);
        o_cmd.out_last  = k_last;

        case (r_state)
            tps_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.take     = i_in_valid;
                o_cmd.new_path = i_first_point || !r_path_open;
            end
            tps_pkg::S_CLR: begin
                o_cmd.sig_we    = 1'b1;
                o_cmd.sig_waddr = tps_pkg::ADDR_W'(r_k);
                o_cmd.sig_wsel  = (r_k == '0) ? tps_pkg::SW_ONE : tps_pkg::SW_ZERO;
            end
            tps_pkg::S_SEG1: begin
                o_cmd.seg_we    = 1'b1;
                o_cmd.seg_waddr = tps_pkg::ADDR_W'(r_k);
                o_cmd.seg_wsel  = (r_k == '0) ? tps_pkg::GW_ONE : tps_pkg::GW_INC;
                o_cmd.inc_sel   = 2'(r_k - 1'b1);
            end
            tps_pkg::S_P_LD: begin
                o_cmd.op = tps_pkg::OP_LOAD;
            end
            tps_pkg::S_P_MUL: begin
                o_cmd.op = tps_pkg::OP_MUL;
            end
            tps_pkg::S_P_RND: begin
                o_cmd.op = tps_pkg::OP_RND;
            end
            tps_pkg::S_P_DIV: begin
                o_cmd.op = tps_pkg::OP_DIV;
            end
            tps_pkg::S_P_FIN: begin
                o_cmd.op     = tps_pkg::OP_FIN;
                o_cmd.seg_we = !r_tens;
            end
            tps_pkg::S_T_WR: begin
                o_cmd.sig_we = 1'b1;
            end
            tps_pkg::S_EM_RD, tps_pkg::S_EM_LD: begin
                o_cmd.sig_raddr = tps_pkg::ADDR_W'(r_k);
                o_cmd.out_load  = (r_state == tps_pkg::S_EM_LD) && i_stat.out_free;
            end
            default: begin
                o_cmd.op = tps_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tps_dp.sv -----
module tps_dp #(
    parameter int DIMS  = 2,
    parameter int TOTAL = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tps_pkg::t_dp_cmd                    i_cmd,
    output tps_pkg::t_dp_stat                   o_stat,
    input  logic signed [tps_pkg::COORD_W-1:0]  i_coord_0,
    input  logic signed [tps_pkg::COORD_W-1:0]  i_coord_1,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [tps_pkg::IDX_W-1:0]           o_term_index,
    output logic signed [tps_pkg::VAL_W-1:0]    o_term_value,
    output logic                                o_last_term,
    output logic                                o_saturated
);

    localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int VW = tps_pkg::VAL_W;
    localparam int AC = tps_pkg::ACC_W;

    logic signed [VW-1:0] sig_mem [TOTAL];
    logic signed [VW-1:0] seg_mem [TOTAL];
    logic signed [VW-1:0] r_sig_rd;
    logic signed [VW-1:0] r_seg_rd;

    logic signed [tps_pkg::COORD_W-1:0] r_prev [DIMS];
    logic signed [tps_pkg::COORD_W-1:0] pt     [DIMS];
    logic signed [VW-1:0]               r_inc  [DIMS];

    logic           r_neg;
    logic [VW-1:0]  r_ua;
    logic [VW-1:0]  r_ub;
    logic [95:0]    r_prod;
    logic [79:0]    r_y;
    logic [79:0]    r_q;
    logic [1:0]     r_rem;
    logic signed [AC-1:0] r_acc;
    logic           r_sat;

    logic                 r_out_valid;
    logic [tps_pkg::IDX_W-1:0] r_out_index;
    logic signed [VW-1:0] r_out_value;
    logic                 r_out_last;
    logic                 r_out_sat;

    logic signed [VW-1:0] b_inc;
    logic signed [VW-1:0] a_op;
    logic signed [VW-1:0] b_op;
    logic [23:0]          a_part;
    logic [23:0]          b_part;
    logic [47:0]          pp;
    logic [95:0]          pp_sh;
    logic [96:0]          rnd_x;
    logic [79:0]          rnd_y;
    logic [9:0]           div_cur;
    logic [20:0]          div_mul;
    logic [7:0]           div_qd;
    logic [9:0]           div_rem;
    logic [79:0]          lim;
    logic                 fin_sat;
    logic [VW-1:0]        fin_mag;
    logic signed [VW-1:0] fin_val;
    logic                 acc_hi;
    logic                 acc_lo;
    logic signed [VW-1:0] acc_val;
    logic signed [VW-1:0] sig_wdata;
    logic signed [VW-1:0] seg_wdata;
    logic                 out_free;

    always_comb begin
        for (int k = 0; k < DIMS; k++) begin
            if (k == 0) begin
                pt[k] = i_coord_0;
            end else if (k == 1) begin
                pt[k] = i_coord_1;
            end else begin
                pt[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIMS; k++) begin
                r_prev[k] <= '0;
            end
        end else if (i_cmd.take) begin
            for (int k = 0; k < DIMS; k++) begin
                r_prev[k] <= pt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [tps_pkg::COORD_W:0] d;
        if (i_cmd.take) begin
            for (int k = 0; k < DIMS; k++) begin
                d = {pt[k][tps_pkg::COORD_W-1], pt[k]}
                    - {r_prev[k][tps_pkg::COORD_W-1], r_prev[k]};
                r_inc[k] <= {{(VW - tps_pkg::COORD_W - 9){d[tps_pkg::COORD_W]}}, d, 8'b0};
            end
        end
    end

    always_comb begin
        b_inc = '0;
        for (int k = 0; k < DIMS; k++) begin
            if (i_cmd.inc_sel == 2'(k)) begin
                b_inc = r_inc[k];
            end
        end
    end

    assign a_op = i_cmd.tens ? r_sig_rd : r_seg_rd;
    assign b_op = i_cmd.tens ? r_seg_rd : b_inc;

    assign a_part = i_cmd.step[1] ? r_ua[47:24] : r_ua[23:0];
    assign b_part = i_cmd.step[0] ? r_ub[47:24] : r_ub[23:0];
    assign pp     = a_part * b_part;

    always_comb begin
        case (i_cmd.step)
            2'd0:    pp_sh = {48'b0, pp};
            2'd3:    pp_sh = {pp, 48'b0};
            default: pp_sh = {24'b0, pp, 24'b0};
        endcase
    end

    assign rnd_x = {1'b0, r_prod} + (97'(i_cmd.m) << 23);
    assign rnd_y = 80'(rnd_x >> 24);

    assign div_cur = {r_rem, r_y[79:72]};
    assign div_mul = 21'(div_cur) * 21'd683;
    assign div_qd  = div_mul[18:11];
    assign div_rem = div_cur - 10'(div_qd) * 10'd3;

    assign lim     = r_neg ? 80'h0000_0000_8000_0000_0000 : 80'h0000_0000_7fff_ffff_ffff;
    assign fin_sat = (r_q > lim);
    assign fin_mag = fin_sat ? lim[VW-1:0] : r_q[VW-1:0];
    assign fin_val = r_neg ? -fin_mag : fin_mag;

    assign acc_hi  = (r_acc > AC'(48'sh7fffffffffff));
    assign acc_lo  = (r_acc < -(AC'(1) <<< (VW - 1)));
    assign acc_val = acc_hi ? 48'sh7fffffffffff :
                     acc_lo ? 48'sh800000000000 : r_acc[VW-1:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tps_pkg::OP_LOAD: begin
                r_neg  <= a_op[VW-1] ^ b_op[VW-1];
                r_ua   <= a_op[VW-1] ? VW'(-a_op) : VW'(a_op);
                r_ub   <= b_op[VW-1] ? VW'(-b_op) : VW'(b_op);
                r_prod <= '0;
            end
            tps_pkg::OP_MUL: begin
                r_prod <= r_prod + pp_sh;
            end
            tps_pkg::OP_RND: begin
                r_y   <= rnd_y;
                r_q   <= (i_cmd.m == 2'd2) ? (rnd_y >> 1) : rnd_y;
                r_rem <= '0;
            end
            tps_pkg::OP_DIV: begin
                r_y   <= r_y << 8;
                r_q   <= {r_q[71:0], div_qd};
                r_rem <= div_rem[1:0];
            end
            tps_pkg::OP_FIN: begin
                if (i_cmd.tens) begin
                    r_acc <= i_cmd.acc_clr ? AC'(fin_val) : r_acc + AC'(fin_val);
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else if (i_cmd.take && i_cmd.new_path) begin
            r_sat <= 1'b0;
        end else if ((i_cmd.op == tps_pkg::OP_FIN && fin_sat)
                     || (i_cmd.sig_we && i_cmd.sig_wsel == tps_pkg::SW_ACC
                         && (acc_hi || acc_lo))) begin
            r_sat <= 1'b1;
        end
    end

    always_comb begin
        case (i_cmd.sig_wsel)
            tps_pkg::SW_ONE:  sig_wdata = tps_pkg::ONE_Q24;
            tps_pkg::SW_ZERO: sig_wdata = '0;
            default:          sig_wdata = acc_val;
        endcase
        case (i_cmd.seg_wsel)
            tps_pkg::GW_ONE: seg_wdata = tps_pkg::ONE_Q24;
            tps_pkg::GW_INC: seg_wdata = b_inc;
            default:         seg_wdata = fin_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sig_we) begin
            sig_mem[i_cmd.sig_waddr[AW-1:0]] <= sig_wdata;
        end
        r_sig_rd <= sig_mem[i_cmd.sig_raddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_we) begin
            seg_mem[i_cmd.seg_waddr[AW-1:0]] <= seg_wdata;
        end
        r_seg_rd <= seg_mem[i_cmd.seg_raddr[AW-1:0]];
    end

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= i_cmd.out_index;
            r_out_value <= r_sig_rd;
            r_out_last  <= i_cmd.out_last;
            r_out_sat   <= r_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_term_index = r_out_index;
    assign o_term_value = r_out_value;
    assign o_last_term  = r_out_last;
    assign o_saturated  = r_out_sat;

endmodule

// ----- hw/rtl/truncated_path_signature.sv -----
// Truncated path signature of a streamed path, folded in point by point.
// i_pt carries one path point per request (coord_0, coord_1, first_point,
// last_point); o_term carries one signature term per request, level-major,
// with last_term on the final term and saturated set if any term clipped
// during the path. Both channels move a request when valid and ready are high.
// A point is taken only while the block is idle. A point that opens a path
// clears the signature store. A later point builds the segment terms and the
// tensor product on one shared 24x24 multiply unit: each product runs read,
// load, four partial products, round and finish, plus a digit divide for
// level-3 segment terms, and each signature term is then written to the
// signature store. With last_point set, the terms follow, each read from the
// store and then loaded into the output register; a stalled receiver holds
// the output register and the block waits. The block takes the next point
// once the final term is registered. Reset closes any open path and drops
// the saturation flag; the signature store holds no defined value until a
// path is opened, the segment store until a later point of that path.
module truncated_path_signature #(
    parameter int DIMS        = 2,
    parameter int TRUNC_LEVEL = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tps_pt_if.sink    i_pt,
    tps_term_if.source o_term
);

    function automatic int lbase(input int l);
        int off;
        int p;
        off = 0;
        p   = 1;
        for (int i = 0; i < 5; i++) begin
            if (i < l) begin
                off = off + p;
                p   = p * DIMS;
            end
        end
        return off;
    endfunction

    localparam int TOTAL = lbase(TRUNC_LEVEL + 1);

    tps_pkg::t_dp_cmd  cmd;
    tps_pkg::t_dp_stat stat;
    logic              in_ready;

    tps_ctrl #(
        .DIMS        (DIMS),
        .TRUNC_LEVEL (TRUNC_LEVEL),
        .TOTAL       (TOTAL)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_pt.valid),
        .i_first_point (i_pt.first_point),
        .i_last_point  (i_pt.last_point),
        .o_in_ready    (in_ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    tps_dp #(
        .DIMS  (DIMS),
        .TOTAL (TOTAL)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_coord_0    (i_pt.coord_0),
        .i_coord_1    (i_pt.coord_1),
        .i_out_ready  (o_term.ready),
        .o_out_valid  (o_term.valid),
        .o_term_index (o_term.term_index),
        .o_term_value (o_term.term_value),
        .o_last_term  (o_term.last_term),
        .o_saturated  (o_term.saturated)
    );

    assign i_pt.ready = in_ready;

endmodule

// ----- tb/testbench.sv -----
module testbench;

    localparam int TERMS = 15;

    typedef struct {
        logic [tps_pkg::IDX_W-1:0] index;
        logic [tps_pkg::VAL_W-1:0] value;
        logic                      last;
        logic                      sat;
    } t_term;

    class signature_board;
        longint sig_terms [TERMS];
        longint seg_terms [TERMS];
        longint prev_pt [2];
        bit     open;
        bit     sat_seen;
        t_term  pending [$];
        int     errors;

        function new();
            foreach (sig_terms[i]) sig_terms[i] = 0;
            foreach (seg_terms[i]) seg_terms[i] = 0;
            prev_pt[0] = 0;
            prev_pt[1] = 0;
            open = 0;
            sat_seen = 0;
            errors = 0;
        endfunction

        function longint clip48(longint v);
            longint hi;
            hi = (longint'(1) <<< 47) - 1;
            if (v > hi) begin
                sat_seen = 1;
                return hi;
            end
            if (v < -(longint'(1) <<< 47)) begin
                sat_seen = 1;
                return -(longint'(1) <<< 47);
            end
            return v;
        endfunction

        // round(a*b/(m*2^24)), ties away from zero, clipped to 48 bits
        function longint scaled_product(longint a, longint b, int m);
            bit         neg;
            bit [63:0]  ua, ub;
            bit [127:0] p, d, q, lim;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            p = {64'b0, ua} * {64'b0, ub};
            d = 128'(m) << 24;
            q = (p + (d >> 1)) / d;
            lim = neg ? (128'(1) << 47) : ((128'(1) << 47) - 1);
            if (q > lim) begin
                sat_seen = 1;
                q = lim;
            end
            return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function int base(int level);
            case (level)
                0: return 0;
                1: return 1;
                2: return 3;
                default: return 7;
            endcase
        endfunction

        function void fold(longint inc [2]);
            longint acc [TERMS];
            int     ro, ao, al, bo, bl;
            foreach (acc[i]) acc[i] = 0;
            seg_terms[0] = 64'sd1 <<< 24;
            seg_terms[1] = clip48(inc[0]);
            seg_terms[2] = clip48(inc[1]);
            for (int m = 2; m <= 3; m++) begin
                for (int i = 0; i < (1 << (m - 1)); i++) begin
                    for (int j = 0; j < 2; j++) begin
                        seg_terms[base(m) + i * 2 + j] =
                            scaled_product(seg_terms[base(m - 1) + i], inc[j], m);
                    end
                end
            end
            for (int m = 0; m <= 3; m++) begin
                ro = base(m);
                for (int j = 0; j <= m; j++) begin
                    ao = base(j);
                    al = 1 << j;
                    bo = base(m - j);
                    bl = 1 << (m - j);
                    for (int u = 0; u < al; u++) begin
                        for (int v = 0; v < bl; v++) begin
                            acc[ro + u * bl + v] +=
                                scaled_product(sig_terms[ao + u], seg_terms[bo + v], 1);
                        end
                    end
                end
            end
            foreach (sig_terms[i]) sig_terms[i] = clip48(acc[i]);
        endfunction

        function void note_point(logic signed [31:0] c0, logic signed [31:0] c1,
                                 logic first, logic last);
            longint inc [2];
            t_term  t;
            if (first || !open) begin
                foreach (sig_terms[i]) sig_terms[i] = 0;
                sig_terms[0] = 64'sd1 <<< 24;
                sat_seen = 0;
                open = 1;
            end else begin
                inc[0] = (longint'(c0) - prev_pt[0]) * 256;
                inc[1] = (longint'(c1) - prev_pt[1]) * 256;
                fold(inc);
            end
            prev_pt[0] = c0;
            prev_pt[1] = c1;
            if (last) begin
                for (int i = 0; i < TERMS; i++) begin
                    t.index = i[tps_pkg::IDX_W-1:0];
                    t.value = sig_terms[i][tps_pkg::VAL_W-1:0];
                    t.last = (i == TERMS - 1);
                    t.sat = sat_seen;
                    pending.push_back(t);
                end
                open = 0;
            end
        endfunction

        function void check_term(logic [tps_pkg::IDX_W-1:0] index,
                                 logic [tps_pkg::VAL_W-1:0] value,
                                 logic last, logic sat);
            t_term t;
            if (pending.size() == 0) begin
                $error("unexpected term index %0d value %h", index, value);
                errors++;
                return;
            end
            t = pending.pop_front();
            if (index !== t.index) begin
                $error("term_index expected %0d actual %0d", t.index, index);
                errors++;
            end
            if (value !== t.value) begin
                $error("term_value expected %h actual %h", t.value, value);
                errors++;
            end
            if (last !== t.last) begin
                $error("last_term expected %b actual %b", t.last, last);
                errors++;
            end
            if (sat !== t.sat) begin
                $error("saturated expected %b actual %b", t.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   points_sent;

    tps_pt_if   pt ();
    tps_term_if term ();

    truncated_path_signature dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .o_term  (term)
    );

    signature_board board = new();

    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function int unsigned draw_wait();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 10);
    endfunction

    function logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 131072)) - 65536;
            default: return $signed($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    task send_point(logic signed [31:0] c0, logic signed [31:0] c1,
                    logic first, logic last);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            pt.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pt.valid       <= 1'b1;
        pt.coord_0     <= c0;
        pt.coord_1     <= c1;
        pt.first_point <= first;
        pt.last_point  <= last;
        do @(posedge i_clk); while (!pt.ready);
        points_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pt.valid && pt.ready)
                board.note_point(pt.coord_0, pt.coord_1, pt.first_point, pt.last_point);
            if (term.valid && term.ready)
                board.check_term(term.term_index, term.term_value,
                                 term.last_term, term.saturated);
        end
    end

    initial begin
        int unsigned stall;
        term.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                term.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            term.ready <= 1'b1;
            do @(posedge i_clk); while (!term.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned len;
        bit          noise;
        pt.valid = 1'b0;
        pt.coord_0 = '0;
        pt.coord_1 = '0;
        pt.first_point = 1'b0;
        pt.last_point = 1'b0;
        points_sent = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes, single point path, point with no open path, restart mid-path
        send_point(32'sh0, 32'sh0, 1, 0);
        send_point(32'sh7fffffff, 32'sh7fffffff, 0, 0);
        send_point(32'sh80000000, 32'sh80000000, 0, 1);
        send_point(32'sh00010000, -32'sh00010000, 1, 1);
        send_point(32'sh00020000, 32'sh00030000, 0, 1);
        send_point(32'sh00010000, 32'sh00020000, 0, 0);
        send_point(32'sh00010000, 32'sh00020000, 0, 0);
        send_point(-32'sh00008000, 32'sh00018000, 0, 0);
        send_point(32'sh00050000, 32'sh00050000, 1, 0);
        send_point(32'sh00060000, 32'sh00040000, 0, 0);
        send_point(32'sh00040000, 32'sh00070000, 0, 1);
        send_point(32'sh80000000, 32'sh7fffffff, 1, 0);
        send_point(32'sh7fffffff, 32'sh80000000, 0, 0);
        send_point(32'sh00000000, 32'sh00000000, 0, 1);
        send_point(32'sh00000001, -32'sh00000001, 1, 0);
        send_point(-32'sh00000001, 32'sh00000001, 0, 1);

        while (points_sent < 460) begin
            len = $urandom_range(1, 6);
            noise = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++) begin
                if (noise)
                    send_point(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                else
                    send_point(rand_coord(), rand_coord(),
                               (i == 0) && ($urandom_range(0, 3) != 0), i == len - 1);
            end
        end
        pt.valid <= 1'b0;

        wait (board.pending.size() == 0);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("testbench: errors");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/tps_pkg.sv
hw/rtl/tps_pt_if.sv
hw/rtl/tps_term_if.sv
hw/rtl/tps_ctrl.sv
hw/rtl/tps_dp.sv
hw/rtl/truncated_path_signature.sv
tb/testbench.sv
